// ===== rtl/gesdh_pkg.sv =====
// Shared types and constants for the graph edge store with degree hash.
`timescale 1ns / 1ps
`default_nettype none

package gesdh_pkg;

	// Fixed field widths of the ports.
	localparam int CMD_W      = 2;
	localparam int VERTEX_W   = 5;
	localparam int COUNT_W    = 6;
	localparam int EDGE_W     = 9;
	localparam int HASH_W     = 30;
	localparam int HASH_OUT_W = 29;
	localparam int DEG_OUT_W  = 5;
	localparam int CFG_W      = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int PAIR_W     = 2;

	// Commands.
	localparam logic [CMD_W-1:0] CMD_CONNECT    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DISCONNECT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ADD_VERTEX = 2'd2;
	localparam logic [CMD_W-1:0] CMD_MARK_MAX   = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_LIMIT     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_VERTICES = 1'd1;

	// Pair states.
	localparam logic [PAIR_W-1:0] PAIR_UNKNOWN       = 2'd0;
	localparam logic [PAIR_W-1:0] PAIR_CONNECTED     = 2'd1;
	localparam logic [PAIR_W-1:0] PAIR_NOT_CONNECTED = 2'd2;

	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_RD_A,
		S_RD_B,
		S_EVAL,
		S_HASH,
		S_WR_A,
		S_WR_B,
		S_FINISH
	} state_t;

	typedef enum logic [1:0] {
		H_IDLE,
		H_LOAD,
		H_MUL,
		H_ACC
	} hash_state_t;

	// Request from the sequencer to the hash unit.
	typedef struct packed {
		logic start;
		logic inc;
	} hash_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/gesdh_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module gesdh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/gesdh_hash_unit.sv =====
// Hash update unit: adds and subtracts four fifth powers with one shared multiplier.
`timescale 1ns / 1ps
`default_nettype none

module gesdh_hash_unit #(
	parameter int DW = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gesdh_pkg::hash_ctl_t       ctl,
	input  logic [DW-1:0]              old_a,
	input  logic [DW-1:0]              old_b,
	output logic                       done,
	output logic [gesdh_pkg::HASH_W-1:0] hash
);

	import gesdh_pkg::*;

	hash_state_t       hstate_q, hstate_d;
	logic [1:0]        term_q;
	logic [1:0]        step_q;
	logic              inc_q;
	logic [DW-1:0]     old_a_q, old_b_q;
	logic [DW-1:0]     new_a, new_b;
	logic [DW-1:0]     term_v;
	logic [HASH_W-1:0] acc_q;
	logic [HASH_W-1:0] hash_q;

	assign new_a = inc_q ? old_a_q + DW'(1) : old_a_q - DW'(1);
	assign new_b = inc_q ? old_b_q + DW'(1) : old_b_q - DW'(1);

	// Even terms are the new degrees (added), odd terms the old ones (subtracted).
	always_comb begin
		case (term_q)
			2'd0:    term_v = new_a;
			2'd1:    term_v = old_a_q;
			2'd2:    term_v = new_b;
			default: term_v = old_b_q;
		endcase
	end

	always_comb begin
		hstate_d = hstate_q;
		done     = 1'b0;
		unique case (hstate_q)
			H_IDLE: begin
				if (ctl.start) begin
					hstate_d = H_LOAD;
				end
			end
			H_LOAD: hstate_d = H_MUL;
			H_MUL: begin
				if (step_q == 2'd3) begin
					hstate_d = H_ACC;
				end
			end
			H_ACC: begin
				if (term_q == 2'd3) begin
					hstate_d = H_IDLE;
					done     = 1'b1;
				end else begin
					hstate_d = H_LOAD;
				end
			end
			default: hstate_d = H_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hstate_q <= H_IDLE;
			hash_q   <= '0;
		end else begin
			hstate_q <= hstate_d;
			if (hstate_q == H_ACC) begin
				hash_q <= term_q[0] ? hash_q - acc_q : hash_q + acc_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (hstate_q)
			H_IDLE: begin
				if (ctl.start) begin
					old_a_q <= old_a;
					old_b_q <= old_b;
					inc_q   <= ctl.inc;
					term_q  <= 2'd0;
				end
			end
			H_LOAD: begin
				acc_q  <= HASH_W'(term_v);
				step_q <= 2'd0;
			end
			H_MUL: begin
				acc_q  <= acc_q * HASH_W'(term_v);
				step_q <= step_q + 2'd1;
			end
			H_ACC: begin
				term_q <= term_q + 2'd1;
			end
			default: ;
		endcase
	end

	assign hash = hash_q;

endmodule

`default_nettype wire

// ===== rtl/graph_edge_store_degree_hash.sv =====
// Top level of the graph edge store: command sequencer, pair and degree stores, counters.
// Each command takes one transfer in and gives one result transfer out. After reset the
// block sweeps the pair store once, VERTEX_SLOTS*VERTEX_SLOTS entries (1024 by default),
// with in_ready low; configuration writes are taken during the sweep. Every command goes
// through two store reads and an evaluation; add vertex, mark maximal and rejected commands
// then load the output. A connect or disconnect that changes nothing passes through the
// degree and pair write states before the output load; one that changes a pair first runs
// the hash unit, which runs four fifth powers through one multiplier. The next command can
// be taken as soon as the result sits in the output register, even while that result waits
// for out_ready.
`timescale 1ns / 1ps
`default_nettype none

module graph_edge_store_degree_hash #(
	parameter int VERTEX_SLOTS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [gesdh_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gesdh_pkg::CFG_W-1:0]        cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [gesdh_pkg::CMD_W-1:0]        command,
	input  logic [gesdh_pkg::VERTEX_W-1:0]     from_vertex,
	input  logic [gesdh_pkg::VERTEX_W-1:0]     to_vertex,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               status,
	output logic [gesdh_pkg::COUNT_W-1:0]      vertex_count,
	output logic [gesdh_pkg::EDGE_W-1:0]       edge_count,
	output logic [gesdh_pkg::HASH_OUT_W-1:0]   degree_hash,
	output logic [gesdh_pkg::DEG_OUT_W-1:0]    head_degree,
	output logic [gesdh_pkg::DEG_OUT_W-1:0]    tail_degree,
	output logic                               maximal
);

	import gesdh_pkg::*;

	localparam int VW         = $clog2(VERTEX_SLOTS);
	localparam int DW         = VW;
	localparam int LW         = $clog2(VERTEX_SLOTS + 1);
	localparam int EW         = $clog2(VERTEX_SLOTS * (VERTEX_SLOTS - 1) / 2 + 1);
	localparam int PAIR_DEPTH = VERTEX_SLOTS * VERTEX_SLOTS;
	localparam int PAW        = $clog2(PAIR_DEPTH);

	state_t               state_q, state_d;
	logic [PAW-1:0]       clr_q;
	logic [CMD_W-1:0]     cmd_q;
	logic [VERTEX_W-1:0]  a_q, b_q;
	logic [DW-1:0]        da_q, db_q;
	logic [DW-1:0]        db_cur;
	logic                 rdv_q;
	logic                 linked_q;
	logic                 upd_q;
	logic                 inc;
	logic [LW-1:0]        live_q;
	logic [EW-1:0]        edges_q;
	logic                 max_q;
	logic [CFG_W-1:0]     limit_q;
	logic [VERTEX_SLOTS-1:0] dvalid_q;

	logic                 out_valid_q;
	logic                 status_q;
	logic                 o_status_q;
	logic [COUNT_W-1:0]   o_count_q;
	logic [EDGE_W-1:0]    o_edges_q;
	logic [HASH_OUT_W-1:0] o_hash_q;
	logic [DEG_OUT_W-1:0] o_from_q, o_to_q;
	logic                 o_max_q;

	logic                 accept;
	logic                 load_out;
	logic                 a_in, b_in;
	logic [VW-1:0]        a_idx, b_idx, lo_idx, hi_idx;
	logic [PAW-1:0]       pidx;
	logic                 pair_cmd, bad_pair, full, change;
	logic [31:0]          lim_eff;
	logic [31:0]          init_sat;

	logic                 deg_we;
	logic [VW-1:0]        deg_waddr, deg_raddr;
	logic [DW-1:0]        deg_wdata, deg_rdata;
	logic                 pair_we;
	logic [PAW-1:0]       pair_waddr;
	logic [PAIR_W-1:0]    pair_wdata, pair_rdata;

	hash_ctl_t            hctl;
	logic                 hdone;
	logic [HASH_W-1:0]    hash;

	assign accept = in_valid && in_ready;
	assign inc    = (cmd_q == CMD_CONNECT);

	assign a_in   = 32'(a_q) < 32'(VERTEX_SLOTS);
	assign b_in   = 32'(b_q) < 32'(VERTEX_SLOTS);
	assign a_idx  = VW'(a_q);
	assign b_idx  = VW'(b_q);
	// The pair store keeps one entry per unordered pair, at the lower endpoint's row.
	assign lo_idx = (a_idx < b_idx) ? a_idx : b_idx;
	assign hi_idx = (a_idx < b_idx) ? b_idx : a_idx;
	assign pidx   = PAW'(32'(lo_idx) * 32'(VERTEX_SLOTS) + 32'(hi_idx));

	assign pair_cmd = (cmd_q == CMD_CONNECT) || (cmd_q == CMD_DISCONNECT);
	assign bad_pair = (32'(a_q) >= 32'(live_q)) || (32'(b_q) >= 32'(live_q)) || (a_q == b_q);
	assign lim_eff  = (32'(limit_q) > 32'(VERTEX_SLOTS)) ? 32'(VERTEX_SLOTS) : 32'(limit_q);
	assign full     = 32'(live_q) >= lim_eff;
	assign change   = inc ? !linked_q : linked_q;
	assign db_cur   = rdv_q ? deg_rdata : '0;
	assign init_sat = (32'(cfg_data) > 32'(VERTEX_SLOTS)) ? 32'(VERTEX_SLOTS) : 32'(cfg_data);

	// Sequencer: next state and store controls.
	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		load_out   = 1'b0;
		hctl.start = 1'b0;
		hctl.inc   = inc;
		deg_we     = 1'b0;
		deg_waddr  = a_idx;
		deg_wdata  = inc ? da_q + DW'(1) : da_q - DW'(1);
		deg_raddr  = a_idx;
		pair_we    = 1'b0;
		pair_waddr = pidx;
		pair_wdata = inc ? PAIR_CONNECTED : PAIR_NOT_CONNECTED;
		unique case (state_q)
			S_CLEAR: begin
				pair_we    = 1'b1;
				pair_waddr = clr_q;
				pair_wdata = PAIR_UNKNOWN;
				if (clr_q == PAW'(PAIR_DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = S_RD_A;
				end
			end
			S_RD_A: state_d = S_RD_B;
			S_RD_B: begin
				deg_raddr = b_idx;
				state_d   = S_EVAL;
			end
			S_EVAL: begin
				if (pair_cmd && !bad_pair) begin
					if (change) begin
						hctl.start = 1'b1;
						state_d    = S_HASH;
					end else begin
						state_d = S_WR_A;
					end
				end else begin
					state_d = S_FINISH;
				end
			end
			S_HASH: begin
				if (hdone) begin
					state_d = S_WR_A;
				end
			end
			S_WR_A: begin
				deg_we  = upd_q;
				state_d = S_WR_B;
			end
			S_WR_B: begin
				deg_we    = upd_q;
				deg_waddr = b_idx;
				deg_wdata = inc ? db_q + DW'(1) : db_q - DW'(1);
				pair_we   = 1'b1;
				state_d   = S_FINISH;
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Control state and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			live_q      <= '0;
			edges_q     <= '0;
			max_q       <= 1'b0;
			limit_q     <= CFG_W'(32);
			dvalid_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + PAW'(1);
			end
			if (deg_we) begin
				dvalid_q[deg_waddr] <= 1'b1;
			end
			if (cfg_write) begin
				case (cfg_index)
					CFG_VERTEX_LIMIT:     limit_q <= cfg_data;
					CFG_INITIAL_VERTICES: live_q  <= LW'(init_sat);
					default: ;
				endcase
			end else if (state_q == S_EVAL && cmd_q == CMD_ADD_VERTEX && !full) begin
				live_q <= live_q + LW'(1);
			end
			if (state_q == S_EVAL && cmd_q == CMD_MARK_MAX) begin
				max_q <= 1'b1;
			end
			if (state_q == S_WR_B && upd_q) begin
				edges_q <= inc ? edges_q + EW'(1) : edges_q - EW'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item registers and output register.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= command;
			a_q   <= from_vertex;
			b_q   <= to_vertex;
		end
		if (state_q == S_RD_A) begin
			rdv_q <= dvalid_q[a_idx] && a_in;
		end
		if (state_q == S_RD_B) begin
			da_q     <= rdv_q ? deg_rdata : '0;
			linked_q <= (pair_rdata == PAIR_CONNECTED);
			rdv_q    <= dvalid_q[b_idx] && b_in;
		end
		if (state_q == S_EVAL) begin
			db_q  <= db_cur;
			upd_q <= pair_cmd && !bad_pair && change;
			if ((pair_cmd && bad_pair) || (cmd_q == CMD_ADD_VERTEX && full)) begin
				status_q <= STATUS_REJECT;
			end else begin
				status_q <= STATUS_OK;
			end
		end
		if (state_q == S_WR_A && upd_q) begin
			da_q <= deg_wdata;
		end
		if (state_q == S_WR_B && upd_q) begin
			db_q <= deg_wdata;
		end
		if (load_out) begin
			o_status_q <= status_q;
			o_count_q  <= COUNT_W'(live_q);
			o_edges_q  <= EDGE_W'(edges_q);
			o_hash_q   <= hash[HASH_W-1:1];
			o_from_q   <= DEG_OUT_W'(da_q);
			o_to_q     <= DEG_OUT_W'(db_q);
			o_max_q    <= max_q;
		end
	end

	gesdh_ram #(
		.WIDTH(DW),
		.DEPTH(VERTEX_SLOTS)
	) u_deg_ram (
		.clk   (clk),
		.we    (deg_we),
		.waddr (deg_waddr),
		.wdata (deg_wdata),
		.raddr (deg_raddr),
		.rdata (deg_rdata)
	);

	gesdh_ram #(
		.WIDTH(PAIR_W),
		.DEPTH(PAIR_DEPTH)
	) u_pair_ram (
		.clk   (clk),
		.we    (pair_we),
		.waddr (pair_waddr),
		.wdata (pair_wdata),
		.raddr (pidx),
		.rdata (pair_rdata)
	);

	gesdh_hash_unit #(
		.DW(DW)
	) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (hctl),
		.old_a  (da_q),
		.old_b  (db_cur),
		.done   (hdone),
		.hash   (hash)
	);

	assign out_valid    = out_valid_q;
	assign status       = o_status_q;
	assign vertex_count = o_count_q;
	assign edge_count   = o_edges_q;
	assign degree_hash  = o_hash_q;
	assign head_degree  = o_from_q;
	assign tail_degree  = o_to_q;
	assign maximal      = o_max_q;

endmodule

`default_nettype wire

// ===== rtl/gesdh_checker.sv =====
// Port-level checks for the graph edge store, attached to the top level by bind.
`timescale 1ns / 1ps
`default_nettype none

module gesdh_checker #(
	parameter int VERTEX_SLOTS = 32
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic                               status,
	input logic [gesdh_pkg::COUNT_W-1:0]      vertex_count,
	input logic [gesdh_pkg::EDGE_W-1:0]       edge_count,
	input logic [gesdh_pkg::HASH_OUT_W-1:0]   degree_hash,
	input logic [gesdh_pkg::DEG_OUT_W-1:0]    head_degree,
	input logic [gesdh_pkg::DEG_OUT_W-1:0]    tail_degree,
	input logic                               maximal
);

	// Only one command is in flight: ready drops right after an input transfer.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a command was in flight");

	// A stalled result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(edge_count)
			&& $stable(degree_hash) && $stable(vertex_count) && $stable(maximal))
		else $error("result changed while stalled");

	// The maximal flag never falls once reported.
	a_max_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && maximal |=> maximal)
		else $error("maximal flag cleared");

	// With no edges every degree is zero, so the hash is zero.
	a_hash_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && edge_count == 0 && VERTEX_SLOTS <= 32 |->
			degree_hash == 0 && head_degree == 0 && tail_degree == 0)
		else $error("nonzero hash or degree with an empty graph");

endmodule

bind graph_edge_store_degree_hash gesdh_checker #(.VERTEX_SLOTS(VERTEX_SLOTS)) u_gesdh_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.vertex_count (vertex_count),
	.edge_count   (edge_count),
	.degree_hash  (degree_hash),
	.head_degree  (head_degree),
	.tail_degree  (tail_degree),
	.maximal      (maximal)
);

`default_nettype wire

// ===== verif/graph_edge_store_degree_hash_tb.sv =====
// Self-checking testbench for the graph edge store with degree hash.
`timescale 1ns / 1ps

module graph_edge_store_degree_hash_tb;
	import gesdh_pkg::*;

	localparam int MAX_V       = 32;
	localparam int CYCLE_LIMIT = 1_000_000;

	typedef struct {
		logic                  status;
		logic [COUNT_W-1:0]    vertex_count;
		logic [EDGE_W-1:0]     edge_count;
		logic [HASH_OUT_W-1:0] degree_hash;
		logic [DEG_OUT_W-1:0]  head_degree;
		logic [DEG_OUT_W-1:0]  tail_degree;
		logic                  maximal;
	} graph_result_t;

	// Tracks the graph, its degrees and hash, and the results still owed by the block.
	class degree_hash_tracker;
		logic [PAIR_W-1:0]    pair_state [MAX_V][MAX_V];
		logic [DEG_OUT_W-1:0] degree [MAX_V];
		longint               hash_sum;
		int unsigned          live;
		int unsigned          edges;
		logic                 marked;
		logic [CFG_W-1:0]     limit_reg;
		graph_result_t        expected_results[$];
		int                   mismatches;

		function new();
			foreach (pair_state[i, j]) pair_state[i][j] = PAIR_UNKNOWN;
			foreach (degree[i]) degree[i] = '0;
			hash_sum   = 0;
			live       = 0;
			edges      = 0;
			marked     = 1'b0;
			limit_reg  = 6'd32;
			mismatches = 0;
		endfunction

		function longint fifth_power(int d);
			longint v;
			v = d;
			return v * v * v * v * v;
		endfunction

		function int unsigned live_count();
			return live;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		function void load_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
			if (idx == CFG_VERTEX_LIMIT) begin
				limit_reg = value;
			end else begin
				// Loading the initial count resizes the live set but keeps every edge.
				live = (value > MAX_V) ? MAX_V : value;
			end
		endfunction

		function void note_command(logic [CMD_W-1:0] cmd, logic [VERTEX_W-1:0] a,
				logic [VERTEX_W-1:0] b);
			graph_result_t r;
			logic          rejected;
			logic          linked;
			int            da;
			int            db;
			rejected = 1'b0;
			da = degree[a];
			db = degree[b];
			if (cmd == CMD_CONNECT || cmd == CMD_DISCONNECT) begin
				if (a >= live || b >= live || a == b) begin
					rejected = 1'b1;
				end else begin
					linked = (pair_state[a][b] == PAIR_CONNECTED);
					if (cmd == CMD_CONNECT) begin
						if (!linked) begin
							hash_sum = hash_sum + fifth_power(da + 1) + fifth_power(db + 1)
								- fifth_power(da) - fifth_power(db);
							degree[a] = DEG_OUT_W'(da + 1);
							degree[b] = DEG_OUT_W'(db + 1);
							edges++;
						end
						pair_state[a][b] = PAIR_CONNECTED;
						pair_state[b][a] = PAIR_CONNECTED;
					end else begin
						// Only a pair that was connected moves the hash and degrees.
						if (linked) begin
							hash_sum = hash_sum + fifth_power(da - 1) + fifth_power(db - 1)
								- fifth_power(da) - fifth_power(db);
							degree[a] = DEG_OUT_W'(da - 1);
							degree[b] = DEG_OUT_W'(db - 1);
							edges--;
						end
						pair_state[a][b] = PAIR_NOT_CONNECTED;
						pair_state[b][a] = PAIR_NOT_CONNECTED;
					end
				end
			end else if (cmd == CMD_ADD_VERTEX) begin
				if (live >= ((limit_reg > MAX_V) ? MAX_V : limit_reg)) begin
					rejected = 1'b1;
				end else begin
					live++;
				end
			end else begin
				marked = 1'b1;
			end
			r.status       = rejected ? STATUS_REJECT : STATUS_OK;
			r.vertex_count = COUNT_W'(live);
			r.edge_count   = EDGE_W'(edges);
			r.degree_hash  = HASH_OUT_W'(hash_sum >> 1);
			r.head_degree  = degree[a];
			r.tail_degree  = degree[b];
			r.maximal      = marked;
			expected_results.push_back(r);
		endfunction

		function void compare_field(string field, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(graph_result_t got);
			graph_result_t want;
			if (expected_results.size() == 0) begin
				$error("result transfer with no command outstanding");
				mismatches++;
				return;
			end
			want = expected_results.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("vertex_count", want.vertex_count, got.vertex_count);
			compare_field("edge_count", want.edge_count, got.edge_count);
			compare_field("degree_hash", want.degree_hash, got.degree_hash);
			compare_field("head_degree", want.head_degree, got.head_degree);
			compare_field("tail_degree", want.tail_degree, got.tail_degree);
			compare_field("maximal", want.maximal, got.maximal);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [CMD_W-1:0]      command = CMD_CONNECT;
	logic [VERTEX_W-1:0]   from_vertex = '0;
	logic [VERTEX_W-1:0]   to_vertex = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  status;
	logic [COUNT_W-1:0]    vertex_count;
	logic [EDGE_W-1:0]     edge_count;
	logic [HASH_OUT_W-1:0] degree_hash;
	logic [DEG_OUT_W-1:0]  head_degree;
	logic [DEG_OUT_W-1:0]  tail_degree;
	logic                  maximal;

	degree_hash_tracker tracker = new();
	bit                 no_idle = 1'b0;
	int                 cycles = 0;

	graph_edge_store_degree_hash #(
		.VERTEX_SLOTS(MAX_V)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.from_vertex(from_vertex),
		.to_vertex(to_vertex),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.vertex_count(vertex_count),
		.edge_count(edge_count),
		.degree_hash(degree_hash),
		.head_degree(head_degree),
		.tail_degree(tail_degree),
		.maximal(maximal)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL graph_edge_store_degree_hash");
			$finish;
		end
	end

	// Mostly no gap, some short ones and now and then a long one.
	function automatic int pick_gap();
		int unsigned roll;
		if (no_idle) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	always begin : result_sink
		int hold;
		@(posedge clk);
		hold = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
		if (hold > 0) begin
			out_ready <= 1'b0;
			repeat (hold) @(posedge clk);
		end
		out_ready <= 1'b1;
	end

	always @(posedge clk) begin : transfer_monitor
		graph_result_t seen;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				seen.status       = status;
				seen.vertex_count = vertex_count;
				seen.edge_count   = edge_count;
				seen.degree_hash  = degree_hash;
				seen.head_degree  = head_degree;
				seen.tail_degree  = tail_degree;
				seen.maximal      = maximal;
				tracker.check_result(seen);
			end
			if (in_valid && in_ready)
				tracker.note_command(command, from_vertex, to_vertex);
		end
	end

	// Valid stays high from one command to the next when there is no gap between them.
	task automatic send_command(logic [CMD_W-1:0] cmd, logic [VERTEX_W-1:0] a,
			logic [VERTEX_W-1:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		command     <= cmd;
		from_vertex <= a;
		to_vertex   <= b;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		tracker.load_register(idx, value);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_graph_config(logic [CFG_W-1:0] limit, logic [CFG_W-1:0] initial_count);
		settle();
		write_register(CFG_VERTEX_LIMIT, limit);
		write_register(CFG_INITIAL_VERTICES, initial_count);
	endtask

	// Connects one vertex to every other one, which drives its degree to the top.
	task automatic star_burst(logic [VERTEX_W-1:0] hub);
		for (int v = 0; v < MAX_V; v++) begin
			if (v != hub)
				send_command(CMD_CONNECT, hub, VERTEX_W'(v));
		end
	endtask

	// Mostly legal pairs among live vertices, with a bias toward a few hub vertices.
	task automatic random_items(int count);
		logic [CMD_W-1:0]    cmd;
		logic [VERTEX_W-1:0] a;
		logic [VERTEX_W-1:0] b;
		int unsigned         live;
		int unsigned         pick;
		repeat (count) begin
			live = tracker.live_count();
			pick = $urandom_range(0, 99);
			a = VERTEX_W'($urandom_range(0, 31));
			b = VERTEX_W'($urandom_range(0, 31));
			if (pick < 55)
				cmd = CMD_CONNECT;
			else if (pick < 80)
				cmd = CMD_DISCONNECT;
			else if (pick < 88)
				cmd = CMD_ADD_VERTEX;
			else if (pick < 91)
				cmd = CMD_MARK_MAX;
			else
				cmd = CMD_W'($urandom_range(0, 3));
			if (pick < 80 && live >= 2) begin
				if ($urandom_range(0, 2) == 0)
					a = VERTEX_W'($urandom_range(0, (live > 4) ? 3 : live - 1));
				else
					a = VERTEX_W'($urandom_range(0, live - 1));
				b = VERTEX_W'($urandom_range(0, live - 2));
				if (b >= a) b++;
			end
			send_command(cmd, a, b);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_register(CFG_VERTEX_LIMIT, 6'd32);
		write_register(CFG_INITIAL_VERTICES, 6'd0);

		// Empty graph, growth, repeated and self pairs, out-of-range endpoints.
		send_command(CMD_CONNECT, 5'd0, 5'd1);
		send_command(CMD_ADD_VERTEX, 5'd31, 5'd0);
		send_command(CMD_ADD_VERTEX, 5'd0, 5'd31);
		send_command(CMD_ADD_VERTEX, 5'd31, 5'd31);
		send_command(CMD_CONNECT, 5'd0, 5'd1);
		send_command(CMD_CONNECT, 5'd1, 5'd0);
		send_command(CMD_CONNECT, 5'd2, 5'd2);
		send_command(CMD_CONNECT, 5'd0, 5'd31);
		send_command(CMD_DISCONNECT, 5'd0, 5'd2);
		send_command(CMD_CONNECT, 5'd1, 5'd2);
		send_command(CMD_DISCONNECT, 5'd1, 5'd0);
		send_command(CMD_DISCONNECT, 5'd31, 5'd30);
		send_command(CMD_MARK_MAX, 5'd1, 5'd2);
		send_command(CMD_MARK_MAX, 5'd31, 5'd31);

		// A limit below the live count keeps the vertices; a zero limit refuses every add.
		settle();
		write_register(CFG_VERTEX_LIMIT, 6'd2);
		send_command(CMD_ADD_VERTEX, 5'd2, 5'd1);
		settle();
		write_register(CFG_VERTEX_LIMIT, 6'd0);
		send_command(CMD_ADD_VERTEX, 5'd0, 5'd1);

		// Oversized values saturate to the full vertex set.
		set_graph_config(6'd63, 6'd63);
		send_command(CMD_ADD_VERTEX, 5'd1, 5'd2);
		send_command(CMD_CONNECT, 5'd31, 5'd30);
		send_command(CMD_CONNECT, 5'd0, 5'd31);
		send_command(CMD_DISCONNECT, 5'd30, 5'd31);
		send_command(CMD_CONNECT, 5'd31, 5'd0);

		// Shrinking the live set leaves degrees in place for the vertices beyond it.
		set_graph_config(6'd40, 6'd0);
		send_command(CMD_CONNECT, 5'd1, 5'd2);
		send_command(CMD_ADD_VERTEX, 5'd31, 5'd0);

		set_graph_config(6'd32, 6'd32);
		star_burst(5'd31);
		random_items(380);

		no_idle = 1'b1;
		set_graph_config(6'd63, 6'd63);
		random_items(250);
		no_idle = 1'b0;

		set_graph_config(6'd12, 6'd4);
		random_items(200);
		set_graph_config(6'd0, 6'd3);
		random_items(100);
		set_graph_config(6'd1, 6'd0);
		random_items(100);

		set_graph_config(CFG_W'($urandom_range(0, 63)), CFG_W'($urandom_range(0, 63)));
		star_burst(VERTEX_W'($urandom_range(0, 31)));
		random_items(380);

		settle();
		repeat (40) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("PASS graph_edge_store_degree_hash");
		else
			$display("FAIL graph_edge_store_degree_hash");
		$finish;
	end

endmodule
